@@ rtl/core/fbc_pkg.sv @@
// Shared types, constants and helpers for the block chain allocator.
// No dependencies; fbc_ctrl, fbc_datapath and the top import it.
package fbc_pkg;

   localparam int NUM_BLOCKS = 1024;
   localparam int FIRST_FREE = 3;
   localparam int ADDR_W     = $clog2(NUM_BLOCKS);

   localparam int MODE_W   = 3;
   localparam int BLOCK_W  = 10;
   localparam int STATUS_W = 2;
   localparam int LINK_W   = 11;
   localparam int COUNT_W  = 11;

   localparam logic [LINK_W-1:0] END_MARK = '1;

   localparam logic [MODE_W-1:0] MODE_FORMAT     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ALLOC      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ALLOC_LINK = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FREE       = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FOLLOW     = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_END_CHAIN = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [BLOCK_W-1:0] block;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BLOCK_W-1:0]  block_out;
      logic [COUNT_W-1:0]  freed_count;
   } rsp_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_FMT_WR,
      DP_ALLOC_RD,
      DP_ALLOC_WR,
      DP_LINK_WR,
      DP_FREE_RD,
      DP_FREE_WR,
      DP_FOL_RD,
      DP_FOL_HEAD,
      DP_FOL_CHK,
      DP_FOL_BAD,
      DP_POST
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              head_ok;
      logic              cur_ok;
      logic              blk_ok;
      logic              blk_range;
      logic              blk_zero;
      logic              fmt_last;
      logic              out_free;
   } sts_type;

   // true for a link that names a real, non-head block
   function automatic logic link_is_block(input logic [LINK_W-1:0] v);
      return (v != '0) && (32'(v) < NUM_BLOCKS);
   endfunction

endpackage

@@ rtl/core/fbc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/fbc_ctrl.sv @@
// Sequencer of the block chain allocator: issues one datapath command a cycle.
// Depends on fbc_pkg. Holds in its done state while the output is stalled.
module fbc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fbc_pkg::sts_type sts,
   output fbc_pkg::cmd_type cmd
);
   import fbc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_FMT,
      S_ALLOC_RD,
      S_ALLOC_WR,
      S_LINK,
      S_FREE_RD,
      S_FREE_WR,
      S_FOL,
      S_FOL_CHK,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;
   dp_op_type op;

   always_comb begin
      state_in = state_ff;
      stall_in = stall_ff;
      op       = DP_NOP;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = DP_LOAD;
               stall_in = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (sts.mode)
               MODE_FORMAT:                state_in = S_FMT;
               MODE_ALLOC, MODE_ALLOC_LINK: state_in = S_ALLOC_RD;
               MODE_FREE:                  state_in = S_FREE_RD;
               MODE_FOLLOW:                state_in = S_FOL;
               default:                    state_in = S_DONE;
            endcase
         end
         S_FMT: begin
            op = DP_FMT_WR;
            if (sts.fmt_last) begin
               state_in = S_DONE;
            end
         end
         S_ALLOC_RD: begin
            op       = DP_ALLOC_RD;
            state_in = sts.head_ok ? S_ALLOC_WR : S_DONE;
         end
         S_ALLOC_WR: begin
            op       = DP_ALLOC_WR;
            state_in = (sts.mode == MODE_ALLOC_LINK && sts.blk_ok) ? S_LINK : S_DONE;
         end
         S_LINK: begin
            op       = DP_LINK_WR;
            state_in = S_DONE;
         end
         S_FREE_RD: begin
            if (sts.cur_ok) begin
               op       = DP_FREE_RD;
               state_in = S_FREE_WR;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FREE_WR: begin
            op       = DP_FREE_WR;
            state_in = S_FREE_RD;
         end
         S_FOL: begin
            priority if (!sts.blk_range) begin
               op       = DP_FOL_BAD;
               state_in = S_DONE;
            end else if (sts.blk_zero) begin
               op       = DP_FOL_HEAD;
               state_in = S_DONE;
            end else begin
               op       = DP_FOL_RD;
               state_in = S_FOL_CHK;
            end
         end
         S_FOL_CHK: begin
            op       = DP_FOL_CHK;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               op       = DP_POST;
               stall_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;
   assign cmd.op    = op;

endmodule

@@ rtl/core/fbc_datapath.sv @@
// Datapath of the block chain allocator: link table RAM, free-list head,
// walk registers and the result register. Depends on fbc_pkg and fbc_ram.
module fbc_datapath (
   input  logic             clock,
   input  logic             reset,
   input  fbc_pkg::req_type req_item,
   output fbc_pkg::rsp_type rsp_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  fbc_pkg::cmd_type cmd,
   output fbc_pkg::sts_type sts
);
   import fbc_pkg::*;

   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [BLOCK_W-1:0]  blk_ff, blk_in;
   logic [LINK_W-1:0]   head_ff, head_in;
   logic [LINK_W-1:0]   cur_ff, cur_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0]   fmt_ff, fmt_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [BLOCK_W-1:0]  res_block_ff, res_block_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                wr_en, rd_en;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   logic [LINK_W-1:0]   wr_data, rd_data;
   logic [LINK_W-1:0]   succ;

   fbc_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BLOCKS)) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign succ = (cmd.op == DP_FOL_HEAD) ? head_ff : rd_data;

   always_comb begin
      mode_in       = mode_ff;
      blk_in        = blk_ff;
      head_in       = head_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      fmt_in        = fmt_ff;
      res_status_in = res_status_ff;
      res_block_in  = res_block_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_stall ? rsp_valid_ff : 1'b0;
      wr_en         = 1'b0;
      wr_addr       = ADDR_W'(cur_ff);
      wr_data       = END_MARK;
      rd_en         = 1'b0;
      rd_addr       = ADDR_W'(cur_ff);
      unique case (cmd.op)
         DP_NOP: begin
         end
         DP_LOAD: begin
            mode_in       = req_item.mode;
            blk_in        = req_item.block;
            cur_in        = LINK_W'(req_item.block);
            cnt_in        = '0;
            fmt_in        = ADDR_W'(1);
            res_status_in = ST_OK;
            res_block_in  = '0;
         end
         DP_FMT_WR: begin
            // roots 1, 2 and the last block terminate, rest chain forward
            wr_en   = 1'b1;
            wr_addr = fmt_ff;
            if (32'(fmt_ff) < FIRST_FREE || 32'(fmt_ff) == NUM_BLOCKS - 1) begin
               wr_data = END_MARK;
            end else begin
               wr_data = LINK_W'(fmt_ff) + LINK_W'(1);
            end
            fmt_in = fmt_ff + ADDR_W'(1);
            if (32'(fmt_ff) == NUM_BLOCKS - 1) begin
               head_in = LINK_W'(FIRST_FREE);
            end
         end
         DP_ALLOC_RD: begin
            rd_en   = link_is_block(head_ff);
            rd_addr = ADDR_W'(head_ff);
            cur_in  = head_ff;
            if (!link_is_block(head_ff)) begin
               res_status_in = ST_NO_FREE;
            end
         end
         DP_ALLOC_WR: begin
            head_in      = rd_data;
            wr_en        = 1'b1;
            wr_data      = END_MARK;
            res_block_in = BLOCK_W'(cur_ff);
         end
         DP_LINK_WR: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(blk_ff);
            wr_data = cur_ff;
         end
         DP_FREE_RD: begin
            rd_en = 1'b1;
         end
         DP_FREE_WR: begin
            // push the current block onto the free list front
            wr_en   = 1'b1;
            wr_data = head_ff;
            head_in = cur_ff;
            cur_in  = rd_data;
            cnt_in  = cnt_ff + COUNT_W'(1);
         end
         DP_FOL_RD: begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(blk_ff);
         end
         DP_FOL_HEAD, DP_FOL_CHK: begin
            if (succ == END_MARK || !(32'(succ) < NUM_BLOCKS)) begin
               res_status_in = ST_END_CHAIN;
            end else begin
               res_block_in = BLOCK_W'(succ);
            end
         end
         DP_FOL_BAD: begin
            res_status_in = ST_END_CHAIN;
         end
         DP_POST: begin
            rsp_in.status      = res_status_ff;
            rsp_in.block_out   = res_block_ff;
            rsp_in.freed_count = cnt_ff;
            rsp_valid_in       = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= END_MARK;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      blk_ff        <= blk_in;
      cur_ff        <= cur_in;
      cnt_ff        <= cnt_in;
      fmt_ff        <= fmt_in;
      res_status_ff <= res_status_in;
      res_block_ff  <= res_block_in;
      rsp_ff        <= rsp_in;
   end

   assign sts.mode      = mode_ff;
   assign sts.head_ok   = link_is_block(head_ff);
   assign sts.cur_ok    = link_is_block(cur_ff) && (32'(cnt_ff) < NUM_BLOCKS);
   assign sts.blk_ok    = link_is_block(LINK_W'(blk_ff));
   assign sts.blk_range = 32'(blk_ff) < NUM_BLOCKS;
   assign sts.blk_zero  = (blk_ff == '0);
   assign sts.fmt_last  = 32'(fmt_ff) == NUM_BLOCKS - 1;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_item  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/fat_block_chain_allocator.sv @@
// Top level of the FAT-style block chain allocator: sequencer plus datapath.
// Depends on fbc_pkg, fbc_ctrl, fbc_datapath and fbc_ram.
//
// One item at a time runs against a 1024-entry link table held in a single
// RAM with one write and one registered read port. Format writes one table
// entry per cycle, from block 1 to the last; allocate reads the free-list
// head's link, then makes it the new head, and for allocate-and-link also
// links the new block after a given one, or reports no free block when the
// list is empty; free chain, for each freed block, reads the link, then
// rewrites it to the old head; follow looks up the successor of a block.
// The next item is taken the cycle after its predecessor's result is posted,
// even if that result still waits in the output register. The table starts
// undefined and needs no clearing pass: run a format before anything else;
// the free list is empty after reset, so an allocate before format reports
// no free block.
module fat_block_chain_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fbc_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fbc_pkg::rsp_type rsp_item
);
   import fbc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequence the table walk one command per cycle, pausing on output stall
   fbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold the link table, head, walk state and the result register
   fbc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // an accepted item always leaves the input side busy next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken again right after an item was accepted");

   // the head rewrite of allocate must follow its head read
   a_alloc_order: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_ALLOC_WR) |-> ($past(cmd.op) == DP_ALLOC_RD))
      else $error("allocate write issued without a preceding head read");

   // a failed allocate or an end of chain never carries a block number
   a_err_no_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != ST_OK) |-> (rsp_item.block_out == '0))
      else $error("error result carries a block number");

   // a result is only posted while the input side is held busy
   a_post_while_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_POST) |-> req_stall)
      else $error("result posted with no item in flight");

endmodule
